// ===== src/single_wildcard_substring_match_macros.svh =====
`ifndef SINGLE_WILDCARD_SUBSTRING_MATCH_MACROS_SVH
`define SINGLE_WILDCARD_SUBSTRING_MATCH_MACROS_SVH

// a implies b in the same cycle
`define SWSM_ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("swsm assertion failed");

// a implies b in the next cycle
`define SWSM_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("swsm assertion failed");

`endif

// ===== src/swsm_pkg.sv =====
`default_nettype none

package swsm_pkg;

  localparam int MAX_PART = 8;
  localparam int IDX_W    = (MAX_PART > 1) ? $clog2(MAX_PART) : 1;
  localparam int LEN_W    = 4;
  localparam int PAT_W    = 64;
  localparam int SINCE_W  = 4;
  localparam int CFG_IDX_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PREFIX_BYTES  = 8'd0,
    REG_PREFIX_LENGTH = 8'd1,
    REG_SUFFIX_BYTES  = 8'd2,
    REG_SUFFIX_LENGTH = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_end;
  } text_item_t;

  typedef struct packed {
    logic found;
    logic final_res;
  } result_item_t;

  typedef struct packed {
    logic [7:0] pre_byte;
    logic [7:0] suf_byte;
  } cell_want_t;

  typedef struct packed {
    logic pre;
    logic suf;
  } cell_hit_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    return (len > LEN_W'(MAX_PART)) ? LEN_W'(MAX_PART) : len;
  endfunction

  function automatic logic [7:0] pick_byte(input logic [PAT_W-1:0] pat,
                                           input logic [LEN_W-1:0] idx);
    logic [PAT_W-1:0] sh;
    sh = pat >> {idx[IDX_W-1:0], 3'b000};
    return sh[7:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/swsm_cell.sv =====
`default_nettype none

module swsm_cell import swsm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       shift_i,
  input  wire logic       clear_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       valid_i,
  input  wire cell_want_t want_i,
  output logic [7:0]      byte_o,
  output logic            valid_o,
  output cell_hit_t       hit_o
);

  logic [7:0] byte_q;
  logic       valid_q;

  // compare the byte that enters this cell on the shift
  assign hit_o.pre = (byte_i == want_i.pre_byte);
  assign hit_o.suf = (byte_i == want_i.suf_byte);

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= valid_i & ~clear_i;
    end
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// ===== src/single_wildcard_substring_match.sv =====
// Single-star wildcard substring matcher.
// Input channel (in_valid_i/in_ready_o/in_item_i) takes one text byte per
// item with a text_end flag on the last byte of a text. Each input item
// yields exactly one result item on the output channel
// (out_valid_o/out_ready_i/out_item_o): found is sticky within the text,
// final_res echoes text_end. After the text_end item the window and flags
// clear and the next byte starts a new text; the pattern registers stay.
// Pattern registers are written through cfg_we_i/cfg_index_i/cfg_data_i
// while the block is idle, a user rule the block does not enforce.
// Lengths above eight count as eight. A result is registered, valid in the
// cycle after its item is accepted. One item per cycle is taken unless the
// output stalls; window cells shift and compare one byte per accepted item
// against the selected pattern bytes. A stalled receiver holds the output
// register; an item is still accepted in the cycle the held result is taken,
// so ready drops only while a result waits and out_ready_i is low. Reset
// clears the window valid bits, flags, output valid and pattern registers.
`default_nettype none
`include "single_wildcard_substring_match_macros.svh"

module single_wildcard_substring_match import swsm_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire text_item_t           in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output result_item_t              out_item_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [PAT_W-1:0]     cfg_data_i
);

  logic [PAT_W-1:0] prefix_q, suffix_q;
  logic [LEN_W-1:0] plen_raw_q, slen_raw_q;
  logic [LEN_W-1:0] plen, slen, plen_m1, slen_m1;

  logic               seen_q, seen_d;
  logic [SINCE_W-1:0] since_q, since_d;
  logic               match_q, match_d;
  logic               out_valid_q;
  result_item_t       out_item_q;

  logic accept;
  logic [MAX_PART-1:0] valid_new;
  logic [7:0]          chain_byte [MAX_PART];
  logic [MAX_PART-1:0] chain_valid;
  cell_want_t          want [MAX_PART];
  cell_hit_t           hit  [MAX_PART];

  logic pre_all, suf_all, pre_ok, suf_ok, pdone, since_ok;

  assign plen    = clamp_len(plen_raw_q);
  assign slen    = clamp_len(slen_raw_q);
  assign plen_m1 = plen - LEN_W'(1);
  assign slen_m1 = slen - LEN_W'(1);

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q   <= '0;
      plen_raw_q <= '0;
      suffix_q   <= '0;
      slen_raw_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PREFIX_BYTES:  prefix_q   <= cfg_data_i;
        REG_PREFIX_LENGTH: plen_raw_q <= cfg_data_i[LEN_W-1:0];
        REG_SUFFIX_BYTES:  suffix_q   <= cfg_data_i;
        REG_SUFFIX_LENGTH: slen_raw_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < MAX_PART; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign valid_new[k] = 1'b1;
      swsm_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (accept),
        .clear_i (in_item_i.text_end),
        .byte_i  (in_item_i.text_byte),
        .valid_i (1'b1),
        .want_i  (want[k]),
        .byte_o  (chain_byte[k]),
        .valid_o (chain_valid[k]),
        .hit_o   (hit[k])
      );
    end else begin : g_body
      assign valid_new[k] = chain_valid[k-1];
      swsm_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (accept),
        .clear_i (in_item_i.text_end),
        .byte_i  (chain_byte[k-1]),
        .valid_i (chain_valid[k-1]),
        .want_i  (want[k]),
        .byte_o  (chain_byte[k]),
        .valid_o (chain_valid[k]),
        .hit_o   (hit[k])
      );
    end
    assign want[k].pre_byte = pick_byte(prefix_q, plen_m1 - LEN_W'(k));
    assign want[k].suf_byte = pick_byte(suffix_q, slen_m1 - LEN_W'(k));
  end

  always_comb begin
    pre_all = 1'b1;
    suf_all = 1'b1;
    for (int k = 0; k < MAX_PART; k++) begin
      pre_all = pre_all & (hit[k].pre | (LEN_W'(k) >= plen));
      suf_all = suf_all & (hit[k].suf | (LEN_W'(k) >= slen));
    end
  end

  assign pre_ok = (plen != '0) & valid_new[plen_m1[IDX_W-1:0]] & pre_all;
  assign suf_ok = valid_new[slen_m1[IDX_W-1:0]] & suf_all;

  always_comb begin
    seen_d  = seen_q;
    since_d = since_q;
    if (seen_q) begin
      if (since_q != '1) begin
        since_d = since_q + SINCE_W'(1);
      end
    end else if (pre_ok) begin
      seen_d  = 1'b1;
      since_d = '0;
    end
  end

  assign pdone    = (plen == '0) | seen_d;
  assign since_ok = (plen == '0) | (since_d >= SINCE_W'(slen));
  assign match_d  = match_q | (pdone & ((slen == '0) | (suf_ok & since_ok)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      since_q     <= '0;
      match_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        out_valid_q <= 1'b1;
        if (in_item_i.text_end) begin
          seen_q  <= 1'b0;
          since_q <= '0;
          match_q <= 1'b0;
        end else begin
          seen_q  <= seen_d;
          since_q <= since_d;
          match_q <= match_d;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q.found     <= match_d;
      out_item_q.final_res <= in_item_i.text_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `SWSM_ASSERT_NEXT(a_end_clears, clk_i, rst_ni, accept && in_item_i.text_end,
                    !seen_q && !match_q && (chain_valid == '0))
  `SWSM_ASSERT_NEXT(a_sticky, clk_i, rst_ni, accept && match_q, out_item_o.found)
  `SWSM_ASSERT_IMPL(a_since_idle, clk_i, rst_ni, !seen_q, since_q == '0)
  `SWSM_ASSERT_NEXT(a_double_star, clk_i, rst_ni,
                    accept && (plen == '0) && (slen == '0), out_item_o.found)

endmodule

`default_nettype wire
